>>> hw/rtl/msws_pkg.sv
package msws_pkg;

    // Default sizes of the block
    localparam int DEF_MAX_COLUMNS = 1024;
    localparam int DEF_MAX_ROWS    = 1024;
    localparam int DEF_MAX_SIDE    = 16;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed widths of the result and configuration words
    localparam int SUM_OUT_BITS   = 24;
    localparam int COUNT_REG_BITS = 11;
    localparam int SIDE_REG_BITS  = 5;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;

    // Entries of the result queue (power of two)
    localparam int RESULT_DEPTH = 8;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_ROW_COUNT    = 2'd0,
        CFG_COLUMN_COUNT = 2'd1,
        CFG_SIDE         = 2'd2
    } cfg_reg_t;

    // Per-word control flags carried down the pipeline
    typedef struct packed {
        logic first_row;
        logic row_full;
        logic first_col;
        logic col_full;
        logic update;
        logic work;
        logic last;
        logic err;
        logic zero;
    } item_flags_t;

    // One queued result word
    typedef struct packed {
        logic signed [SUM_OUT_BITS-1:0] sum;
        logic                           err;
    } result_t;

endpackage

>>> hw/rtl/msws_ram.sv
module msws_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [WIDTH-1:0]     wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port; registered read returns the old contents on a collision
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hw/rtl/max_square_window_sum.sv
// Stage 1 forms column sums, stage 2 the window sum; stage 3 the maximum, queued at frame end.
// Throughput: one word per cycle while in_stall is low; the line store and column-sum RAMs
// take one read and one write per cycle, with a one-deep bypass from the column-sum stage.
// in_stall rises only when queued plus in-flight results fill the 8-entry result queue.
// Reset: positions, window sum, best sum, queue and config (all counts 1) are reset at once;
// RAM contents are left as they are and need no clearing pass.
module max_square_window_sum #(
    parameter int MAX_COLUMNS = msws_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = msws_pkg::DEF_MAX_ROWS,
    parameter int MAX_SIDE    = msws_pkg::DEF_MAX_SIDE,
    parameter int SAMPLE_BITS = msws_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [SAMPLE_BITS-1:0]          sample_value,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [msws_pkg::SUM_OUT_BITS-1:0] max_sum,
    output logic                                   size_error,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [msws_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [msws_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    import msws_pkg::*;

    localparam int CPW       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int RPW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW       = $clog2(MAX_COLUMNS + 1);
    localparam int RCW       = $clog2(MAX_ROWS + 1);
    localparam int SIDE_BITS = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int SNW       = $clog2(MAX_SIDE + 1);
    localparam int GROW      = $clog2(MAX_SIDE);
    localparam int COL_BITS  = SAMPLE_BITS + GROW + 1;
    localparam int WIN_BITS  = SAMPLE_BITS + 2 * GROW + 1;
    localparam int STORE_AW  = SIDE_BITS + CPW;
    localparam int FQ_PW     = $clog2(RESULT_DEPTH);
    localparam int FQ_CW     = $clog2(RESULT_DEPTH + 1);
    localparam logic signed [WIN_BITS-1:0] BEST_MIN = {1'b1, {(WIN_BITS - 1){1'b0}}};

    // Configuration registers
    logic [COUNT_REG_BITS-1:0] row_count_reg;
    logic [COUNT_REG_BITS-1:0] column_count_reg;
    logic [SIDE_REG_BITS-1:0]  side_reg;

    logic [RCW-1:0] rows_eff;
    logic [CCW-1:0] cols_eff;
    logic [SNW-1:0] side_eff;

    // Frame position
    logic [RPW-1:0]       row_pos_reg, row_pos_next;
    logic [CPW-1:0]       col_pos_reg, col_pos_next;
    logic [SIDE_BITS-1:0] row_slot_reg, row_slot_next;
    logic [SIDE_BITS-1:0] col_slot_reg, col_slot_next;
    logic [SIDE_BITS-1:0] row_slot_wrap, col_slot_wrap;
    logic                 last_col, last_row, frame_end;
    logic                 accept;
    item_flags_t          in_flags;

    // Stage 1: RAM read data, column sum
    logic                          s1_valid_reg;
    item_flags_t                   s1_flags_reg;
    logic signed [SAMPLE_BITS-1:0] s1_sample_reg;
    logic [SIDE_BITS-1:0]          s1_row_slot_reg;
    logic [CPW-1:0]                s1_col_reg;
    logic [SIDE_BITS-1:0]          s1_col_slot_reg;
    logic                          s1_write;
    logic [STORE_AW-1:0]           store_rd_addr, store_wr_addr;
    logic [SAMPLE_BITS-1:0]        store_rdata;
    logic [COL_BITS-1:0]           colsum_rdata;
    logic                          byp_store_hit_reg, byp_col_hit_reg;
    logic signed [SAMPLE_BITS-1:0] byp_store_reg;
    logic signed [COL_BITS-1:0]    byp_col_reg;
    logic signed [SAMPLE_BITS-1:0] store_old;
    logic signed [COL_BITS-1:0]    col_old;
    logic signed [COL_BITS-1:0]    colsum;

    // Stage 2: sliding window sum
    logic                       s2_valid_reg;
    item_flags_t                s2_flags_reg;
    logic signed [COL_BITS-1:0] s2_colsum_reg;
    logic [SIDE_BITS-1:0]       s2_col_slot_reg;
    logic signed [COL_BITS-1:0] delay_reg [MAX_SIDE];
    logic signed [WIN_BITS-1:0] window_reg, window_next;

    // Stage 3: running maximum, result push
    logic                       s3_valid_reg;
    item_flags_t                s3_flags_reg;
    logic signed [WIN_BITS-1:0] best_reg, best_next, best_cand;
    logic                       push;
    result_t                    push_word;

    // Result queue
    result_t           fifo_reg [RESULT_DEPTH];
    logic [FQ_PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [FQ_CW-1:0]  fifo_count_reg;
    logic              pop;
    logic [1:0]        inflight_count;

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= COUNT_REG_BITS'(1);
            column_count_reg <= COUNT_REG_BITS'(1);
            side_reg         <= SIDE_REG_BITS'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ROW_COUNT:    row_count_reg    <= cfg_data[COUNT_REG_BITS-1:0];
                CFG_COLUMN_COUNT: column_count_reg <= cfg_data[COUNT_REG_BITS-1:0];
                CFG_SIDE:         side_reg         <= cfg_data[SIDE_REG_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // Clamp counts and window edge
    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = RCW'(1);
        else if (32'(row_count_reg) > MAX_ROWS)
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(row_count_reg);

        if (column_count_reg == '0)
            cols_eff = CCW'(1);
        else if (32'(column_count_reg) > MAX_COLUMNS)
            cols_eff = CCW'(MAX_COLUMNS);
        else
            cols_eff = CCW'(column_count_reg);

        if (32'(side_reg) > MAX_SIDE)
            side_eff = SNW'(MAX_SIDE);
        else
            side_eff = SNW'(side_reg);
    end

    // Frame position and flags of the incoming word
    assign accept    = in_valid && !in_stall;
    assign last_col  = (32'(col_pos_reg) + 32'd1) >= 32'(cols_eff);
    assign last_row  = (32'(row_pos_reg) + 32'd1) >= 32'(rows_eff);
    assign frame_end = last_col && last_row;

    assign row_slot_wrap = ((32'(row_slot_reg) + 32'd1) >= 32'(side_eff)) ?
                           '0 : row_slot_reg + SIDE_BITS'(1);
    assign col_slot_wrap = ((32'(col_slot_reg) + 32'd1) >= 32'(side_eff)) ?
                           '0 : col_slot_reg + SIDE_BITS'(1);

    always_comb
    begin
        in_flags.first_row = (row_pos_reg == '0);
        in_flags.row_full  = 32'(row_pos_reg) >= 32'(side_eff);
        in_flags.first_col = (col_pos_reg == '0);
        in_flags.col_full  = 32'(col_pos_reg) >= 32'(side_eff);
        in_flags.update    = ((32'(row_pos_reg) + 32'd1) >= 32'(side_eff)) &&
                             ((32'(col_pos_reg) + 32'd1) >= 32'(side_eff));
        in_flags.work      = (side_eff != '0);
        in_flags.last      = frame_end;
        in_flags.err       = (32'(side_reg) > 32'(rows_eff)) ||
                             (32'(side_reg) > 32'(cols_eff));
        in_flags.zero      = (side_eff == '0);
    end

    always_comb
    begin
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        row_slot_next = row_slot_reg;
        col_slot_next = col_slot_reg;
        if (accept)
        begin
            if (frame_end)
            begin
                row_pos_next  = '0;
                col_pos_next  = '0;
                row_slot_next = '0;
                col_slot_next = '0;
            end
            else if (last_col)
            begin
                row_pos_next  = row_pos_reg + RPW'(1);
                col_pos_next  = '0;
                row_slot_next = row_slot_wrap;
                col_slot_next = '0;
            end
            else
            begin
                col_pos_next  = col_pos_reg + CPW'(1);
                col_slot_next = col_slot_wrap;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            col_pos_reg  <= '0;
            row_slot_reg <= '0;
            col_slot_reg <= '0;
        end
        else
        begin
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            row_slot_reg <= row_slot_next;
            col_slot_reg <= col_slot_next;
        end
    end

    // Line store and column sums
    assign store_rd_addr = {row_slot_reg, col_pos_reg};
    assign store_wr_addr = {s1_row_slot_reg, s1_col_reg};
    assign s1_write      = s1_valid_reg && s1_flags_reg.work;

    msws_ram #(
        .WIDTH     (SAMPLE_BITS),
        .DEPTH     (2 ** STORE_AW),
        .ADDR_BITS (STORE_AW)
    ) u_row_store (
        .clk     (clk),
        .wr_en   (s1_write),
        .wr_addr (store_wr_addr),
        .wr_data (s1_sample_reg),
        .rd_en   (accept),
        .rd_addr (store_rd_addr),
        .rd_data (store_rdata)
    );

    msws_ram #(
        .WIDTH     (COL_BITS),
        .DEPTH     (2 ** CPW),
        .ADDR_BITS (CPW)
    ) u_column_sums (
        .clk     (clk),
        .wr_en   (s1_write),
        .wr_addr (s1_col_reg),
        .wr_data (colsum),
        .rd_en   (accept),
        .rd_addr (col_pos_reg),
        .rd_data (colsum_rdata)
    );

    // Catch the write that collides with this cycle's read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_store_hit_reg <= 1'b0;
            byp_col_hit_reg   <= 1'b0;
        end
        else
        begin
            byp_store_hit_reg <= s1_write && (store_rd_addr == store_wr_addr);
            byp_col_hit_reg   <= s1_write && (col_pos_reg == s1_col_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        byp_store_reg <= s1_sample_reg;
        byp_col_reg   <= colsum;
    end

    // Stage 1 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_flags_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (accept)
            begin
                s1_flags_reg <= in_flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg   <= sample_value;
            s1_row_slot_reg <= row_slot_reg;
            s1_col_reg      <= col_pos_reg;
            s1_col_slot_reg <= col_slot_reg;
        end
    end

    // Update the column sum: add the new row, drop the row leaving the window
    assign store_old = byp_store_hit_reg ? byp_store_reg : $signed(store_rdata);
    assign col_old   = byp_col_hit_reg ? byp_col_reg : $signed(colsum_rdata);

    always_comb
    begin
        if (s1_flags_reg.first_row)
            colsum = COL_BITS'(s1_sample_reg);
        else if (s1_flags_reg.row_full)
            colsum = col_old + COL_BITS'(s1_sample_reg) - COL_BITS'(store_old);
        else
            colsum = col_old + COL_BITS'(s1_sample_reg);
    end

    // Stage 2 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_flags_reg <= '0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
            s2_flags_reg <= s1_flags_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_colsum_reg   <= colsum;
        s2_col_slot_reg <= s1_col_slot_reg;
    end

    // Slide the window: add the new column sum, drop the one leaving
    always_comb
    begin
        window_next = window_reg;
        if (s2_valid_reg && s2_flags_reg.work)
        begin
            if (s2_flags_reg.first_col)
                window_next = WIN_BITS'(s2_colsum_reg);
            else if (s2_flags_reg.col_full)
                window_next = window_reg + WIN_BITS'(s2_colsum_reg)
                              - WIN_BITS'(delay_reg[s2_col_slot_reg]);
            else
                window_next = window_reg + WIN_BITS'(s2_colsum_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else
        begin
            window_reg <= window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s2_flags_reg.work)
        begin
            delay_reg[s2_col_slot_reg] <= s2_colsum_reg;
        end
    end

    // Stage 3 registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s3_flags_reg <= '0;
        end
        else
        begin
            s3_valid_reg <= s2_valid_reg;
            s3_flags_reg <= s2_flags_reg;
        end
    end

    // Track the best full window; restart it at frame end
    assign best_cand = (s3_flags_reg.update && s3_flags_reg.work && (window_reg > best_reg)) ?
                       window_reg : best_reg;
    assign push      = s3_valid_reg && s3_flags_reg.last;

    always_comb
    begin
        best_next = best_reg;
        if (s3_valid_reg)
        begin
            best_next = s3_flags_reg.last ? BEST_MIN : best_cand;
        end
        push_word.err = s3_flags_reg.err;
        if (s3_flags_reg.err || s3_flags_reg.zero)
            push_word.sum = '0;
        else
            push_word.sum = SUM_OUT_BITS'(best_cand);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= BEST_MIN;
        end
        else
        begin
            best_reg <= best_next;
        end
    end

    // Result queue
    assign out_valid  = (fifo_count_reg != '0);
    assign pop        = out_valid && !out_stall;
    assign max_sum    = fifo_reg[rd_ptr_reg].sum;
    assign size_error = fifo_reg[rd_ptr_reg].err;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FQ_PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FQ_PW'(1);
            end
            if (push && !pop)
                fifo_count_reg <= fifo_count_reg + FQ_CW'(1);
            else if (pop && !push)
                fifo_count_reg <= fifo_count_reg - FQ_CW'(1);
        end
    end

    // Hold input while queued plus in-flight results could overrun the queue
    assign inflight_count = 2'(s1_valid_reg && s1_flags_reg.last)
                          + 2'(s2_valid_reg && s2_flags_reg.last)
                          + 2'(s3_valid_reg && s3_flags_reg.last);
    assign in_stall = (32'(fifo_count_reg) + 32'(inflight_count)) >= RESULT_DEPTH;

    // Checks
    a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(fifo_count_reg) + 32'(inflight_count)) <= RESULT_DEPTH)
        else $error("result queue credit exceeded");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_end) |=>
        (row_pos_reg == '0 && col_pos_reg == '0 && row_slot_reg == '0 && col_slot_reg == '0))
        else $error("position not cleared after frame end");

    a_best_restart: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (best_reg == BEST_MIN))
        else $error("best sum not restarted after result");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(row_slot_reg) < MAX_SIDE) && (32'(col_slot_reg) < MAX_SIDE))
        else $error("slot counter out of range");

endmodule

>>> tb/tb_max_square_window_sum.sv
module tb_max_square_window_sum;
    timeunit 1ns;
    timeprecision 1ps;

    import msws_pkg::*;

    localparam int MAX_COLUMNS    = DEF_MAX_COLUMNS;
    localparam int MAX_ROWS       = DEF_MAX_ROWS;
    localparam int MAX_SIDE       = DEF_MAX_SIDE;
    localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
    localparam int RESULT_LATENCY = 3;
    localparam longint PEAK_FLOOR = -(longint'(1) << 24);

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

    typedef enum int { FILL_RANDOM, FILL_MAX, FILL_MIN } fill_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [SAMPLE_BITS-1:0]       sample_value;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [SUM_OUT_BITS-1:0]      max_sum;
    logic                                size_error;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [CFG_INDEX_BITS-1:0]           cfg_index;
    logic [CFG_DATA_BITS-1:0]            cfg_data;

    // Shadow copy of the block's state and registers
    longint                      line_store [MAX_SIDE*MAX_COLUMNS];
    longint                      col_totals [MAX_COLUMNS];
    longint                      col_tap [MAX_SIDE];
    longint                      run_sum = 0;
    longint                      peak_sum = PEAK_FLOOR;
    int unsigned                 cur_row = 0;
    int unsigned                 cur_col = 0;
    logic [COUNT_REG_BITS-1:0]   cfg_rows = 1;
    logic [COUNT_REG_BITS-1:0]   cfg_cols = 1;
    logic [SIDE_REG_BITS-1:0]    cfg_side = 1;

    result_t                     peak_queue [$];
    result_t                     want;
    int                          errors = 0;
    int                          send_idle_pct = 0;
    int                          stall_pct = 0;

    max_square_window_sum u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_value (sample_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .max_sum      (max_sum),
        .size_error   (size_error),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Zero and oversize counts map into 1..hi
    function automatic int unsigned count_limit(input logic [COUNT_REG_BITS-1:0] v,
                                                input int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void restart_frame();
        run_sum = 0;
        peak_sum = PEAK_FLOOR;
        cur_row = 0;
        cur_col = 0;
    endfunction

    // Advance the shadow state by one accepted word; queue the frame result at the end
    function automatic void predict_window_peak(input logic signed [SAMPLE_BITS-1:0] value);
        longint      x;
        longint      col_total;
        int unsigned rows;
        int unsigned cols;
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned idx;
        int unsigned slot;
        logic        flag;
        result_t     res;
        x = value;
        rows = count_limit(cfg_rows, MAX_ROWS);
        cols = count_limit(cfg_cols, MAX_COLUMNS);
        n = (cfg_side > MAX_SIDE) ? MAX_SIDE : cfg_side;
        r = cur_row;
        c = cur_col;
        if (n > 0 && c < MAX_COLUMNS)
        begin
            // column sum over the last n rows
            idx = (r % n) * MAX_COLUMNS + c;
            if (r == 0)
                col_total = x;
            else
            begin
                col_total = col_totals[c] + x;
                if (r >= n)
                    col_total -= line_store[idx];
            end
            line_store[idx] = x;
            col_totals[c] = col_total;
            // horizontal sum over the last n column sums
            slot = c % n;
            if (c == 0)
                run_sum = col_total;
            else
            begin
                run_sum += col_total;
                if (c >= n)
                    run_sum -= col_tap[slot];
            end
            col_tap[slot] = col_total;
            if (r + 1 >= n && c + 1 >= n && run_sum > peak_sum)
                peak_sum = run_sum;
        end
        if (c + 1 >= cols && r + 1 >= rows)
        begin
            flag = (cfg_side > rows) || (cfg_side > cols);
            res.sum = (flag || n == 0) ? '0 : peak_sum[SUM_OUT_BITS-1:0];
            res.err = flag;
            peak_queue.push_back(res);
            restart_frame();
        end
        else if (c + 1 >= cols)
        begin
            cur_col = 0;
            cur_row = r + 1;
        end
        else
            cur_col = c + 1;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input fill_t fill);
        case (fill)
            FILL_MAX: return SAMPLE_MAX;
            FILL_MIN: return SAMPLE_MIN;
            default:
            begin
                if ($urandom_range(7) == 0)
                    return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
                return SAMPLE_BITS'($urandom_range(65535));
            end
        endcase
    endfunction

    // Randomly stall the result side
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (peak_queue.size() == 0)
            begin
                $display("%0t: unexpected result word: max_sum %0d size_error %0b",
                         $time, max_sum, size_error);
                errors++;
            end
            else
            begin
                want = peak_queue.pop_front();
                if (max_sum !== want.sum)
                begin
                    $display("%0t: max_sum expected %0d actual %0d",
                             $time, want.sum, max_sum);
                    errors++;
                end
                if (size_error !== want.err)
                begin
                    $display("%0t: size_error expected %0b actual %0b",
                             $time, want.err, size_error);
                    errors++;
                end
            end
        end
    end

    // Send one sample word; hold it until accepted. Enter and leave at a falling edge.
    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        sample_value <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_window_peak(value);
        @(negedge clk);
    endtask

    // Drop valid and hold off until every expected result is in and the pipe is empty
    task automatic settle_block();
        in_valid <= 1'b0;
        while (peak_queue.size() != 0)
            @(negedge clk);
        repeat (RESULT_LATENCY + 2)
            @(negedge clk);
    endtask

    // Write one register; valid is left high for a following write
    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (which)
            CFG_ROW_COUNT:    cfg_rows = data;
            CFG_COLUMN_COUNT: cfg_cols = data;
            CFG_SIDE:         cfg_side = data[SIDE_REG_BITS-1:0];
            default:          ;
        endcase
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_BITS-1:0] rows,
                             input logic [CFG_DATA_BITS-1:0] cols,
                             input logic [CFG_DATA_BITS-1:0] side_data);
        settle_block();
        write_reg(CFG_ROW_COUNT, rows);
        write_reg(CFG_COLUMN_COUNT, cols);
        write_reg(CFG_SIDE, side_data);
        cfg_valid <= 1'b0;
    endtask

    // Stream one full frame under the current registers
    task automatic send_frame(input fill_t fill, output int count);
        count = count_limit(cfg_rows, MAX_ROWS) * count_limit(cfg_cols, MAX_COLUMNS);
        repeat (count)
            send_sample(pick_sample(fill));
    endtask

    // After reset each word is a whole 1x1 frame
    task automatic test_single_samples();
        send_idle_pct = 36;
        stall_pct = 36;
        send_sample(SAMPLE_MAX);
        send_sample(SAMPLE_MIN);
        send_sample(16'sh0000);
        send_sample(-16'sd1);
        send_sample(16'sh5555);
        send_sample(16'shAAAA);
    endtask

    task automatic test_window_corners();
        int count;
        // plain 3x3 frame, 2x2 window
        set_frame(3, 3, 2);
        for (int i = 0; i < 9; i++)
            send_sample(SAMPLE_BITS'((i * 7) % 11 - 5));
        // window taller than the frame
        set_frame(1, 3, 2);
        send_frame(FILL_RANDOM, count);
        // window wider than the frame
        set_frame(3, 1, 2);
        send_frame(FILL_RANDOM, count);
        // empty window
        set_frame(2, 2, 0);
        send_frame(FILL_RANDOM, count);
        // zero counts act as one
        set_frame(0, 0, 1);
        send_frame(FILL_RANDOM, count);
        // largest side register value on a tiny frame
        set_frame(1, 1, 31);
        send_frame(FILL_RANDOM, count);
    endtask

    // Side above the window limit is clamped when the frame is big enough;
    // all-max words drive the window sum to its top
    task automatic test_side_clamp();
        int count;
        send_idle_pct = 52;
        stall_pct = 0;
        set_frame(17, 17, 17);
        send_frame(FILL_MAX, count);
    endtask

    task automatic random_frames(input int items_goal, input int frames_goal);
        int                       sent;
        int                       frames;
        int                       count;
        int                       k;
        int unsigned              rows;
        int unsigned              cols;
        int unsigned              side;
        int unsigned              lo;
        logic [CFG_DATA_BITS-1:0] side_data;
        sent = 0;
        frames = 0;
        while (sent < items_goal || frames < frames_goal)
        begin
            // mostly reshape between frames; otherwise stream frames back to back
            if (frames == 0 || $urandom_range(9) < 7)
            begin
                k = $urandom_range(99);
                if (k < 70)
                begin
                    rows = $urandom_range(1, 6);
                    cols = $urandom_range(1, 8);
                    lo = (rows < cols) ? rows : cols;
                    side = $urandom_range(1, lo);
                end
                else if (k < 78)
                begin
                    rows = $urandom_range(1, 4);
                    cols = $urandom_range(1, 4);
                    lo = (rows < cols) ? rows : cols;
                    side = $urandom_range(lo + 1, 31);
                end
                else if (k < 85)
                begin
                    rows = $urandom_range(1, 4);
                    cols = $urandom_range(1, 4);
                    side = 0;
                end
                else if (k < 92)
                begin
                    if ($urandom_range(1))
                    begin
                        rows = 0;
                        cols = $urandom_range(1, 6);
                    end
                    else
                    begin
                        rows = $urandom_range(1, 6);
                        cols = 0;
                    end
                    side = $urandom_range(0, 1);
                end
                else
                begin
                    rows = $urandom_range(8, 12);
                    cols = $urandom_range(8, 12);
                    lo = (rows < cols) ? rows : cols;
                    side = $urandom_range(1, (lo < MAX_SIDE) ? lo : MAX_SIDE);
                end
                // upper data bits are outside the side register
                side_data = CFG_DATA_BITS'(($urandom_range(63) << SIDE_REG_BITS) | side);
                set_frame(CFG_DATA_BITS'(rows), CFG_DATA_BITS'(cols), side_data);
            end
            send_frame(FILL_RANDOM, count);
            sent += count;
            frames++;
        end
    endtask

    task automatic test_random_frames();
        send_idle_pct = 0;
        stall_pct = 0;
        random_frames(25, 3);
        send_idle_pct = 52;
        stall_pct = 0;
        random_frames(25, 3);
        send_idle_pct = 0;
        stall_pct = 52;
        random_frames(25, 3);
        send_idle_pct = 36;
        stall_pct = 36;
        random_frames(25, 3);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample_value = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROW_COUNT;
        cfg_data = '0;
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_single_samples();
        test_window_corners();
        test_side_clamp();
        test_random_frames();

        settle_block();
        if (errors == 0 && peak_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #10ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
